/* src/tcet_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the pattern cell translator.
// No dependencies.
package tcet_pkg;

   // Playable note range and the offset applied to it
   localparam logic [7:0] NOTE_LAST  = 8'd36;
   localparam logic [7:0] NOTE_SHIFT = 8'd48;

   // Raw effect codes
   localparam logic [7:0] FX_PORTA_DOWN     = 8'd1;
   localparam logic [7:0] FX_PORTA_UP       = 8'd2;
   localparam logic [7:0] FX_ARPEGGIO       = 8'd12;
   localparam logic [7:0] FX_SLIDE_DOWN     = 8'd13;
   localparam logic [7:0] FX_FILTER         = 8'd15;
   localparam logic [7:0] FX_SLIDE_UP_ONCE  = 8'd17;
   localparam logic [7:0] FX_SLIDE_DN_ONCE  = 8'd21;
   localparam logic [7:0] FX_JUMP           = 8'd25;
   localparam logic [7:0] FX_RELEASE        = 8'd27;
   localparam logic [7:0] FX_SPEED          = 8'd28;
   localparam logic [7:0] FX_SLIDE_UP       = 8'd30;
   localparam logic [7:0] FX_VOLUME         = 8'd31;

   // Normalized command codes
   localparam logic [3:0] CMD_NOP        = 4'd0;
   localparam logic [3:0] CMD_PORTA_DOWN = 4'd1;
   localparam logic [3:0] CMD_PORTA_UP   = 4'd2;
   localparam logic [3:0] CMD_ARP        = 4'd3;
   localparam logic [3:0] CMD_SLIDE_DOWN = 4'd4;
   localparam logic [3:0] CMD_SLIDE_UP   = 4'd5;
   localparam logic [3:0] CMD_EXTENDED   = 4'd6;
   localparam logic [3:0] CMD_JUMP       = 4'd7;
   localparam logic [3:0] CMD_TEMPO      = 4'd8;
   localparam logic [3:0] CMD_VOL_SLIDE  = 4'd9;
   localparam logic [3:0] CMD_LAST       = CMD_VOL_SLIDE;

   // Parameter rewrite constants
   localparam logic [3:0] SLIDE_TAG      = 4'h1;
   localparam logic [3:0] SLIDE_ONCE_TAG = 4'h5;
   localparam logic [7:0] VOLUME_MAX     = 8'h40;
   localparam logic [3:0] NIBBLE_MAX_F   = 4'hF;
   localparam logic [3:0] NIBBLE_MAX_E   = 4'hE;

   typedef struct packed {
      logic [7:0] note_byte;
      logic [7:0] instrument_byte;
      logic [7:0] effect_byte;
      logic [7:0] param_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] note_out;
      logic       key_off;
      logic [7:0] instrument_out;
      logic [3:0] command_out;
      logic [7:0] param_out;
      logic       vol_set;
      logic [6:0] volume_out;
   } rsp_word_type;

   // Effect decode result passed from the effect translator to the top level
   typedef struct packed {
      logic       key_off;
      logic [3:0] command;
      logic [7:0] param;
      logic       vol_set;
      logic [6:0] volume;
   } fx_result_type;

endpackage

/* src/tcet_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on tcet_pkg.
interface tcet_req_if import tcet_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tcet_rsp_if import tcet_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* src/tracker_cell_effect_translator_top.sv */
`timescale 1ns / 1ps
// Pattern cell translator: input word register, translation logic, result register.
// An accepted word is held in the input word register, then loaded into the result register.
// Throughput: one word per cycle while rsp is not held; the result register stalls only while rsp is held.
// Reset (synchronous, active high) clears both stage valid flags; data is not reset.
// Depends on tcet_pkg, tcet_if, tcet_note_xlate, tcet_effect_xlate.
module tracker_cell_effect_translator_top import tcet_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tcet_req_if.sink          req_chan,
   tcet_rsp_if.source        rsp_chan
);

   logic          in_valid_ff;
   logic          in_valid_in;
   req_word_type  in_word_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_word_type  out_word_ff;
   rsp_word_type  out_word_in;
   logic          out_ready;
   logic          in_ready;
   logic [7:0]    note;
   logic [7:0]    instrument;
   fx_result_type fx;

   assign out_ready      = !out_valid_ff || rsp_chan.ready;
   assign in_ready       = !in_valid_ff || out_ready;
   assign req_chan.ready = in_ready;

   assign in_valid_in  = req_chan.valid || (in_valid_ff && !out_ready);
   assign out_valid_in = in_valid_ff || (out_valid_ff && !rsp_chan.ready);

   tcet_note_xlate u_note (
      .note_byte       (in_word_ff.note_byte),
      .instrument_byte (in_word_ff.instrument_byte),
      .note            (note),
      .instrument      (instrument)
   );

   tcet_effect_xlate u_effect (
      .effect_byte (in_word_ff.effect_byte),
      .param_byte  (in_word_ff.param_byte),
      .fx          (fx)
   );

   always_comb begin
      out_word_in.note_out       = fx.key_off ? 8'd0 : note;
      out_word_in.key_off        = fx.key_off;
      out_word_in.instrument_out = fx.key_off ? 8'd0 : instrument;
      out_word_in.command_out    = fx.command;
      out_word_in.param_out      = fx.param;
      out_word_in.vol_set        = fx.vol_set;
      out_word_in.volume_out     = fx.volume;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
      if (in_ready && req_chan.valid) begin
         in_word_ff <= req_chan.data;
      end
      if (out_ready && in_valid_ff) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_word_ff;

endmodule

/* src/tcet_note_xlate.sv */
`timescale 1ns / 1ps
// Note and instrument translation, combinational.
// Depends on tcet_pkg.
module tcet_note_xlate import tcet_pkg::*; (
   input  logic [7:0] note_byte,
   input  logic [7:0] instrument_byte,
   output logic [7:0] note,
   output logic [7:0] instrument
);

   logic playable;

   assign playable = (note_byte != 8'd0) && (note_byte <= NOTE_LAST);

   always_comb begin
      if (playable) begin
         note       = note_byte + NOTE_SHIFT;
         instrument = instrument_byte + 8'd1;   // wraps mod 256
      end else begin
         note       = note_byte;
         instrument = 8'd0;
      end
   end

endmodule

/* src/tcet_effect_xlate.sv */
`timescale 1ns / 1ps
// Effect code and parameter translation, combinational.
// Depends on tcet_pkg.
module tcet_effect_xlate import tcet_pkg::*; (
   input  logic [7:0]    effect_byte,
   input  logic [7:0]    param_byte,
   output fx_result_type fx
);

   logic       param_nz;
   logic [3:0] lo;
   logic [3:0] hi;
   logic [3:0] lo_clamp_f;
   logic [3:0] lo_clamp_e;
   logic [3:0] p_clamp_f;

   assign param_nz   = (param_byte != 8'd0);
   assign lo         = param_byte[3:0];
   assign hi         = param_byte[7:4];
   assign lo_clamp_f = lo;
   assign lo_clamp_e = (lo == NIBBLE_MAX_F) ? NIBBLE_MAX_E : lo;
   // min(param, 0xF) over the whole byte
   assign p_clamp_f  = (hi != 4'd0) ? NIBBLE_MAX_F : lo_clamp_f;

   always_comb begin
      fx.key_off = 1'b0;
      fx.command = CMD_NOP;
      fx.param   = 8'd0;
      fx.vol_set = 1'b0;
      fx.volume  = 7'd0;
      case (effect_byte)
         FX_PORTA_DOWN: begin
            fx.command = CMD_PORTA_DOWN;
            fx.param   = {4'd0, lo};
         end
         FX_PORTA_UP: begin
            fx.command = CMD_PORTA_UP;
            fx.param   = {4'd0, lo};
         end
         FX_ARPEGGIO: begin
            if (param_nz) begin
               fx.command = CMD_ARP;
               fx.param   = param_byte;
            end
         end
         FX_SLIDE_DOWN: begin
            if (param_nz) begin
               fx.command = CMD_SLIDE_DOWN;
               fx.param   = {SLIDE_TAG, p_clamp_f};
            end
         end
         FX_SLIDE_UP: begin
            if (param_nz) begin
               fx.command = CMD_SLIDE_UP;
               fx.param   = {SLIDE_TAG, p_clamp_f};
            end
         end
         FX_SLIDE_DN_ONCE: begin
            if (param_nz) begin
               fx.command = CMD_SLIDE_DOWN;
               fx.param   = {SLIDE_ONCE_TAG, p_clamp_f};
            end
         end
         FX_SLIDE_UP_ONCE: begin
            if (param_nz) begin
               fx.command = CMD_SLIDE_UP;
               fx.param   = {SLIDE_ONCE_TAG, p_clamp_f};
            end
         end
         FX_FILTER: begin
            fx.command = CMD_EXTENDED;
            fx.param   = {7'd0, param_nz};
         end
         FX_JUMP: begin
            fx.command = CMD_JUMP;
            fx.param   = param_byte;
         end
         FX_SPEED: begin
            fx.command = CMD_TEMPO;
            fx.param   = param_byte;
         end
         FX_RELEASE: begin
            fx.key_off = 1'b1;
         end
         FX_VOLUME: begin
            // 0x00..0x3F and exactly 0x40 set volume; 0x41..0x7F are slides
            if ((param_byte[7:6] == 2'd0) || (param_byte == VOLUME_MAX)) begin
               fx.vol_set = 1'b1;
               fx.volume  = param_byte[6:0];
            end else begin
               case (hi)
                  4'd4: begin
                     fx.command = CMD_VOL_SLIDE;
                     fx.param   = {4'd0, lo};
                  end
                  4'd5: begin
                     fx.command = CMD_VOL_SLIDE;
                     fx.param   = {lo, 4'd0};
                  end
                  4'd6: begin
                     fx.command = CMD_VOL_SLIDE;
                     fx.param   = {NIBBLE_MAX_F, lo_clamp_e};
                  end
                  4'd7: begin
                     fx.command = CMD_VOL_SLIDE;
                     fx.param   = {lo_clamp_e, NIBBLE_MAX_F};
                  end
                  default: begin
                     fx.command = CMD_NOP;
                     fx.param   = 8'd0;
                  end
               endcase
            end
         end
         default: begin
            fx.command = CMD_NOP;
            fx.param   = 8'd0;
         end
      endcase
   end

endmodule

/* src/tcet_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the pattern cell translator, bound to the top level.
// Depends on tcet_pkg.
module tcet_checker import tcet_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   // a stalled result word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word changed");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // key-off clears the rest of the cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.key_off |->
         rsp_data.note_out == 8'd0 && rsp_data.instrument_out == 8'd0 &&
         rsp_data.command_out == CMD_NOP && rsp_data.param_out == 8'd0 &&
         !rsp_data.vol_set)
      else $error("key-off word carries other fields");

   // set-volume carries no command and stays in range; otherwise volume is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.vol_set && rsp_data.command_out == CMD_NOP &&
          rsp_data.param_out == 8'd0 && rsp_data.volume_out <= VOLUME_MAX[6:0]) ||
         (!rsp_data.vol_set && rsp_data.volume_out == 7'd0))
      else $error("volume column inconsistent");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.command_out <= CMD_LAST)
      else $error("command out of range");

endmodule

bind tracker_cell_effect_translator_top tcet_checker u_tcet_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the pattern cell translator: directed and random cells
// under random sender gaps and receiver stalls. Depends on tcet_pkg, tcet_if and
// tracker_cell_effect_translator_top.
module tb;
   import tcet_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_CELLS = 500;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned REPORT_MAX = 10;

   // Holds the expected events in order and checks each one that comes out.
   class cell_event_board;
      rsp_word_type pending_events[$];
      int unsigned  mismatch_count = 0;

      function automatic rsp_word_type translate_cell(req_word_type c);
         rsp_word_type r;
         logic [3:0]   hi;
         logic [3:0]   lo;
         logic [3:0]   lo_e;
         logic [3:0]   par_f;
         r = '0;
         hi = c.param_byte[7:4];
         lo = c.param_byte[3:0];
         lo_e = (lo > NIBBLE_MAX_E) ? NIBBLE_MAX_E : lo;
         par_f = (c.param_byte > {4'h0, NIBBLE_MAX_F}) ? NIBBLE_MAX_F : lo;
         if (c.note_byte >= 8'd1 && c.note_byte <= NOTE_LAST) begin
            r.note_out = c.note_byte + NOTE_SHIFT;
            r.instrument_out = c.instrument_byte + 8'd1;
         end else begin
            r.note_out = c.note_byte;
            r.instrument_out = 8'd0;
         end
         r.command_out = CMD_NOP;
         r.param_out = 8'd0;
         case (c.effect_byte)
            FX_PORTA_DOWN: begin
               r.command_out = CMD_PORTA_DOWN;
               r.param_out = {4'h0, lo};
            end
            FX_PORTA_UP: begin
               r.command_out = CMD_PORTA_UP;
               r.param_out = {4'h0, lo};
            end
            FX_ARPEGGIO: begin
               if (c.param_byte != 8'd0) begin
                  r.command_out = CMD_ARP;
                  r.param_out = c.param_byte;
               end
            end
            FX_SLIDE_DOWN: begin
               if (c.param_byte != 8'd0) begin
                  r.command_out = CMD_SLIDE_DOWN;
                  r.param_out = {SLIDE_TAG, par_f};
               end
            end
            FX_SLIDE_UP: begin
               if (c.param_byte != 8'd0) begin
                  r.command_out = CMD_SLIDE_UP;
                  r.param_out = {SLIDE_TAG, par_f};
               end
            end
            FX_SLIDE_DN_ONCE: begin
               if (c.param_byte != 8'd0) begin
                  r.command_out = CMD_SLIDE_DOWN;
                  r.param_out = {SLIDE_ONCE_TAG, par_f};
               end
            end
            FX_SLIDE_UP_ONCE: begin
               if (c.param_byte != 8'd0) begin
                  r.command_out = CMD_SLIDE_UP;
                  r.param_out = {SLIDE_ONCE_TAG, par_f};
               end
            end
            FX_FILTER: begin
               r.command_out = CMD_EXTENDED;
               r.param_out = {7'd0, c.param_byte != 8'd0};
            end
            FX_JUMP: begin
               r.command_out = CMD_JUMP;
               r.param_out = c.param_byte;
            end
            FX_SPEED: begin
               r.command_out = CMD_TEMPO;
               r.param_out = c.param_byte;
            end
            FX_RELEASE: begin
               r.note_out = 8'd0;
               r.instrument_out = 8'd0;
               r.key_off = 1'b1;
            end
            FX_VOLUME: begin
               // high nibbles 0..3 and exactly 0x40 set the volume, 4..7 are slides
               if (hi <= 4'd3 || c.param_byte == VOLUME_MAX) begin
                  r.vol_set = 1'b1;
                  r.volume_out = c.param_byte[6:0];
               end else if (hi == 4'd4) begin
                  r.command_out = CMD_VOL_SLIDE;
                  r.param_out = {4'h0, lo};
               end else if (hi == 4'd5) begin
                  r.command_out = CMD_VOL_SLIDE;
                  r.param_out = {lo, 4'h0};
               end else if (hi == 4'd6) begin
                  r.command_out = CMD_VOL_SLIDE;
                  r.param_out = {NIBBLE_MAX_F, lo_e};
               end else if (hi == 4'd7) begin
                  r.command_out = CMD_VOL_SLIDE;
                  r.param_out = {lo_e, NIBBLE_MAX_F};
               end
            end
            default: begin
            end
         endcase
         return r;
      endfunction

      function void note_cell(req_word_type c);
         pending_events.insert(pending_events.size(), translate_cell(c));
      endfunction

      function void check_event(rsp_word_type got);
         rsp_word_type exp;
         bit           bad;
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: unexpected event word %h", $realtime, got);
            return;
         end
         exp = pending_events.pop_front();
         bad = (got.note_out !== exp.note_out) || (got.key_off !== exp.key_off) ||
               (got.instrument_out !== exp.instrument_out) ||
               (got.command_out !== exp.command_out) ||
               (got.param_out !== exp.param_out) || (got.vol_set !== exp.vol_set) ||
               (got.volume_out !== exp.volume_out);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: event mismatch note %h/%h koff %b/%b ins %h/%h ",
                        $realtime, exp.note_out, got.note_out, exp.key_off, got.key_off,
                        exp.instrument_out, got.instrument_out,
                        "cmd %0d/%0d par %h/%h vs %b/%b vol %h/%h (exp/got)",
                        exp.command_out, got.command_out, exp.param_out, got.param_out,
                        exp.vol_set, got.vol_set, exp.volume_out, got.volume_out);
         end
      endfunction

      function int unsigned pending();
         return pending_events.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycle_count = 0;
   int unsigned rx_phase = 0;
   cell_event_board events_sb = new();

   tcet_req_if req_if ();
   tcet_rsp_if rsp_if ();

   tracker_cell_effect_translator_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // accepted words on both channels
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         events_sb.note_cell(req_if.data);
      if (!reset && rsp_if.valid && rsp_if.ready)
         events_sb.check_event(rsp_if.data);
   end

   // receiver cycles through free running, light, heavy and long stall phases
   always @(negedge clock) begin
      rx_phase <= rx_phase + 1;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_phase[8:7])
            2'd0: rsp_if.ready <= 1'b1;
            2'd1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_if.ready <= ($urandom_range(0, 1) != 0);
            default: rsp_if.ready <= (rx_phase[2:0] == 3'd0);
         endcase
      end
   end

   function automatic req_word_type make_cell(logic [7:0] n, logic [7:0] i,
                                              logic [7:0] e, logic [7:0] p);
      return {n, i, e, p};
   endfunction

   task automatic push_cell(req_word_type c);
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.data = c;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic idle_sender(int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         req_if.data = $urandom;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (events_sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_effect();
      case ($urandom_range(0, 13))
         0: return FX_PORTA_DOWN;
         1: return FX_PORTA_UP;
         2: return FX_ARPEGGIO;
         3: return FX_SLIDE_DOWN;
         4: return FX_SLIDE_UP;
         5: return FX_SLIDE_DN_ONCE;
         6: return FX_SLIDE_UP_ONCE;
         7: return FX_FILTER;
         8: return FX_JUMP;
         9: return FX_SPEED;
         10: return FX_RELEASE;
         11, 12: return FX_VOLUME;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_param();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'($urandom_range(1, 16));
         2: return 8'($urandom_range('h40, 'h7F));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_word_type random_cell();
      logic [7:0] n;
      n = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 36)) : 8'($urandom_range(0, 255));
      return make_cell(n, 8'($urandom_range(0, 255)), pick_effect(), pick_param());
   endfunction

   initial begin
      int unsigned sent;
      int unsigned burst;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // note and instrument extremes, every effect, zero params and clamp edges
      push_cell(make_cell(8'd0, 8'd0, 8'd0, 8'hFF));
      push_cell(make_cell(8'd1, 8'd255, FX_PORTA_DOWN, 8'hFF));
      push_cell(make_cell(8'd36, 8'd0, FX_PORTA_UP, 8'hA5));
      push_cell(make_cell(8'd37, 8'd255, FX_ARPEGGIO, 8'd0));
      push_cell(make_cell(8'd255, 8'd7, FX_ARPEGGIO, 8'h37));
      push_cell(make_cell(8'd12, 8'd3, FX_SLIDE_DOWN, 8'd0));
      push_cell(make_cell(8'd12, 8'd3, FX_SLIDE_DOWN, 8'h0F));
      push_cell(make_cell(8'd20, 8'd9, FX_SLIDE_UP, 8'h10));
      push_cell(make_cell(8'd20, 8'd9, FX_SLIDE_UP, 8'd0));
      push_cell(make_cell(8'd5, 8'd1, FX_SLIDE_DN_ONCE, 8'h03));
      push_cell(make_cell(8'd5, 8'd1, FX_SLIDE_UP_ONCE, 8'hFF));
      push_cell(make_cell(8'd5, 8'd1, FX_SLIDE_UP_ONCE, 8'd0));
      push_cell(make_cell(8'd6, 8'd2, FX_FILTER, 8'd0));
      push_cell(make_cell(8'd6, 8'd2, FX_FILTER, 8'h80));
      push_cell(make_cell(8'd0, 8'd2, FX_JUMP, 8'hFF));
      push_cell(make_cell(8'd0, 8'd2, FX_SPEED, 8'h06));
      push_cell(make_cell(8'd30, 8'd44, FX_RELEASE, 8'hFF));
      push_cell(make_cell(8'd1, 8'd0, FX_VOLUME, 8'h3F));
      push_cell(make_cell(8'd1, 8'd0, FX_VOLUME, 8'h40));
      push_cell(make_cell(8'd1, 8'd0, FX_VOLUME, 8'h4F));
      push_cell(make_cell(8'd1, 8'd0, FX_VOLUME, 8'h5A));
      push_cell(make_cell(8'd1, 8'd0, FX_VOLUME, 8'h6F));
      push_cell(make_cell(8'd1, 8'd0, FX_VOLUME, 8'h7E));
      push_cell(make_cell(8'd1, 8'd0, FX_VOLUME, 8'h80));
      push_cell(make_cell(8'd100, 8'd0, 8'd128, 8'h55));
      push_cell(make_cell(8'd36, 8'd255, 8'd255, 8'hAA));

      sent = 0;
      while (sent < RANDOM_CELLS) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && sent < RANDOM_CELLS) begin
            push_cell(random_cell());
            sent++;
            burst--;
            if (sent == RANDOM_CELLS / 2) begin
               // hold off until the pipeline has emptied
               idle_sender(1);
               wait_drained();
            end
         end
         // stretch of back-to-back words in the middle of the run
         if (sent < 150 || sent > 250)
            idle_sender($urandom_range(0, 6));
      end
      idle_sender(1);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (events_sb.mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

/* sim.f */
src/tcet_pkg.sv
src/tcet_if.sv
src/tcet_note_xlate.sv
src/tcet_effect_xlate.sv
src/tracker_cell_effect_translator_top.sv
src/tcet_checker.sv
sim/tb.sv
